// ----- hdl/mmhs_pkg.sv -----
// shared constants, opcode and state types for the mergeable min-heap sets block
// no dependencies
package mmhs_pkg;

  localparam int ELEM_COUNT = 1024;
  localparam int IDX_W      = $clog2(ELEM_COUNT);
  localparam int IN_IDX_W   = 10;
  localparam int VAL_W      = 32;
  localparam int KIND_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_MERGE   = 2'd1,
    KIND_EXTRACT = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD_WR,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    cnt_inc;
    logic    scan_issue;
    logic    clr_wr;
    logic    load_wr;
    logic    finish_ext;
  } dp_cmd_t;

  typedef struct packed {
    logic  cnt_last;
    kind_t kind;
    logic  range_a;
    logic  range_b;
    logic  label_a_is_a;
    logic  merge_ok;
    logic  rem_a;
  } dp_stat_t;

endpackage

// ----- hdl/mmhs_dp.sv -----
// datapath: label/removed memory, value memory, scan counter, minimum and relabel logic
// depends on mmhs_pkg
module mmhs_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mmhs_pkg::dp_cmd_t                       cmd,
  output mmhs_pkg::dp_stat_t                      stat,
  input  logic [mmhs_pkg::KIND_W-1:0]             in_kind,
  input  logic [mmhs_pkg::IN_IDX_W-1:0]           in_first_index,
  input  logic [mmhs_pkg::IN_IDX_W-1:0]           in_second_index,
  input  logic signed [mmhs_pkg::VAL_W-1:0]       in_load_value,
  output logic                                    out_valid,
  output logic signed [mmhs_pkg::VAL_W-1:0]       out_min_value,
  output logic                                    out_is_empty
);
  import mmhs_pkg::*;

  logic [IDX_W:0]     lab_mem [ELEM_COUNT];
  logic [VAL_W-1:0]   val_mem [ELEM_COUNT];

  kind_t              kind_r;
  logic [IDX_W-1:0]   a_r, b_r;
  logic signed [VAL_W-1:0] v_r;
  logic               range_a_r, range_b_r;
  logic [IDX_W-1:0]   lab_a_r, lab_b_r;
  logic               rem_a_r;
  logic [IDX_W-1:0]   cnt_r;
  logic               pend_r;
  logic [IDX_W-1:0]   pend_idx_r;
  logic               heir_found_r;
  logic [IDX_W-1:0]   heir_r;
  logic               best_found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic signed [VAL_W-1:0] best_val_r;
  logic               out_valid_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic               out_empty_r;

  logic [IDX_W:0]     lab_q;
  logic [VAL_W-1:0]   val_q;
  logic               q_rem;
  logic [IDX_W-1:0]   q_lab;
  logic [IDX_W-1:0]   rd_addr;
  logic               cnt_last;

  logic               lab_we;
  logic [IDX_W-1:0]   lab_waddr;
  logic [IDX_W:0]     lab_wdata;
  logic               load_hit, merge_hit, ext_hit, ext_better;

  assign q_rem    = lab_q[IDX_W];
  assign q_lab    = lab_q[IDX_W-1:0];
  assign cnt_last = (cnt_r == IDX_W'(ELEM_COUNT - 1));

  // status to controller
  always_comb begin
    stat.cnt_last     = cnt_last;
    stat.kind         = kind_r;
    stat.range_a      = range_a_r;
    stat.range_b      = range_b_r;
    stat.label_a_is_a = (lab_a_r == a_r);
    stat.merge_ok     = !rem_a_r && !q_rem && (q_lab != lab_a_r);
    stat.rem_a        = rem_a_r;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_A:    rd_addr = a_r;
      RD_B:    rd_addr = b_r;
      RD_SCAN: rd_addr = cnt_r;
      default: rd_addr = cnt_r;
    endcase
  end

  // per-entry scan decisions on the returned read data
  assign load_hit   = pend_r && (kind_r == KIND_LOAD) && (pend_idx_r != a_r) && (q_lab == a_r);
  assign merge_hit  = pend_r && (kind_r == KIND_MERGE) && (q_lab == lab_b_r);
  assign ext_hit    = pend_r && (kind_r == KIND_EXTRACT) && (q_lab == lab_a_r) && !q_rem;
  assign ext_better = ext_hit && (!best_found_r || ($signed(val_q) < best_val_r));

  always_comb begin
    lab_we    = 1'b0;
    lab_waddr = pend_idx_r;
    lab_wdata = lab_q;
    priority if (cmd.clr_wr) begin
      lab_we    = 1'b1;
      lab_waddr = cnt_r;
      lab_wdata = {1'b0, cnt_r};
    end else if (cmd.load_wr) begin
      lab_we    = 1'b1;
      lab_waddr = a_r;
      lab_wdata = {1'b0, a_r};
    end else if (cmd.finish_ext) begin
      lab_we    = best_found_r;
      lab_waddr = best_idx_r;
      lab_wdata = {1'b1, lab_a_r};
    end else if (load_hit) begin
      lab_we    = 1'b1;
      lab_wdata = {q_rem, (heir_found_r ? heir_r : pend_idx_r)};
    end else if (merge_hit) begin
      lab_we    = 1'b1;
      lab_wdata = {q_rem, lab_a_r};
    end else begin
      lab_we    = 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_waddr] <= lab_wdata;
    end
    if (cmd.load_wr) begin
      val_mem[a_r] <= v_r;
    end
    if (cmd.rd_en) begin
      lab_q <= lab_mem[rd_addr];
      val_q <= val_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r    <= kind_t'(in_kind);
      a_r       <= IDX_W'(in_first_index);
      b_r       <= IDX_W'(in_second_index);
      v_r       <= in_load_value;
      range_a_r <= (32'(in_first_index) < 32'(ELEM_COUNT));
      range_b_r <= (32'(in_second_index) < 32'(ELEM_COUNT));
    end
    if (cmd.cap_a) begin
      lab_a_r <= q_lab;
      rem_a_r <= q_rem;
    end
    if (cmd.cap_b) begin
      lab_b_r <= q_lab;
    end
    if (cmd.scan_issue) begin
      pend_idx_r <= cnt_r;
    end
    if (load_hit && !heir_found_r) begin
      heir_r <= pend_idx_r;
    end
    if (ext_better) begin
      best_idx_r <= pend_idx_r;
      best_val_r <= $signed(val_q);
    end
    if (cmd.finish_ext) begin
      out_val_r   <= best_found_r ? best_val_r : -32'sd1;
      out_empty_r <= !best_found_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      heir_found_r <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
      end
      pend_r      <= cmd.scan_issue;
      out_valid_r <= cmd.finish_ext;
      if (cmd.latch_in) begin
        heir_found_r <= 1'b0;
        best_found_r <= 1'b0;
      end else begin
        if (load_hit) begin
          heir_found_r <= 1'b1;
        end
        if (ext_better) begin
          best_found_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_val_r;
  assign out_is_empty  = out_empty_r;

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.finish_ext))
    else $error("result strobe without extract finish");

  a_no_clear_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !pend_r && !cmd.scan_issue)
    else $error("clearing write overlaps a scan");

  a_best_only_extract: assert property (@(posedge clk) disable iff (!rst_n)
    best_found_r |-> kind_r == KIND_EXTRACT)
    else $error("minimum tracked outside extract");

  a_heir_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    heir_found_r |-> kind_r == KIND_LOAD)
    else $error("heir tracked outside load");

endmodule

// ----- hdl/mmhs_ctrl.sv -----
// controller state machine: clearing pass, operand fetch, scan sequencing, result
// depends on mmhs_pkg
module mmhs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mmhs_pkg::dp_stat_t  stat,
  output mmhs_pkg::dp_cmd_t   cmd
);
  import mmhs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (stat.cnt_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (start) state_nxt = ST_FETCH_A;
      ST_FETCH_A: state_nxt = ST_FETCH_B;
      ST_FETCH_B: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        unique case (stat.kind)
          KIND_LOAD: begin
            priority if (!stat.range_a) state_nxt = ST_IDLE;
            else if (stat.label_a_is_a) state_nxt = ST_SCAN;
            else state_nxt = ST_LOAD_WR;
          end
          KIND_MERGE: begin
            if (stat.range_a && stat.range_b && stat.merge_ok) state_nxt = ST_SCAN;
            else state_nxt = ST_IDLE;
          end
          KIND_EXTRACT: begin
            if (stat.range_a && !stat.rem_a) state_nxt = ST_SCAN;
            else state_nxt = ST_FINISH;
          end
          KIND_NOP: state_nxt = ST_IDLE;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN:    if (stat.cnt_last) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        unique case (stat.kind)
          KIND_LOAD:    state_nxt = ST_LOAD_WR;
          KIND_EXTRACT: state_nxt = ST_FINISH;
          default:      state_nxt = ST_IDLE;
        endcase
      end
      ST_LOAD_WR: state_nxt = ST_IDLE;
      ST_FINISH:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_SCAN;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_IDLE: cmd.latch_in = start;
      ST_FETCH_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_A;
      end
      ST_FETCH_B: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_B;
      end
      ST_DECIDE: cmd.cap_b = 1'b1;
      ST_SCAN: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_SCAN;
        cmd.cnt_inc    = 1'b1;
        cmd.scan_issue = 1'b1;
      end
      ST_DRAIN:   cmd.rd_en = 1'b0;
      ST_LOAD_WR: cmd.load_wr = 1'b1;
      ST_FINISH:  cmd.finish_ext = 1'b1;
      default:    cmd.rd_en = 1'b0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && stat.cnt_last) |=> state_r == ST_DRAIN)
    else $error("scan did not end in drain");

  a_accept_fetches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> busy && state_r == ST_FETCH_A)
    else $error("accepted transaction not fetched");

  a_finish_only_extract: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> stat.kind == KIND_EXTRACT)
    else $error("finish reached for non-extract transaction");

endmodule

// ----- hdl/mergeable_min_heap_sets_core.sv -----
// top level: controller and datapath of the mergeable min-heap sets block
// depends on mmhs_pkg, mmhs_ctrl, mmhs_dp
// extract: the result strobe follows a full memory scan, which is skipped when the
// target is removed or out of range; merge and load likewise either skip or run the
// scan, and the memory scan reads one entry per cycle
// reset: a clearing pass over all ELEM_COUNT entries holds busy high; results cannot be stalled
module mergeable_min_heap_sets_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mmhs_pkg::KIND_W-1:0]          in_kind,
  input  logic [mmhs_pkg::IN_IDX_W-1:0]        in_first_index,
  input  logic [mmhs_pkg::IN_IDX_W-1:0]        in_second_index,
  input  logic signed [mmhs_pkg::VAL_W-1:0]    in_load_value,
  output logic                                 out_valid,
  output logic signed [mmhs_pkg::VAL_W-1:0]    out_min_value,
  output logic                                 out_is_empty
);
  import mmhs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mmhs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mmhs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_load_value   (in_load_value),
    .out_valid       (out_valid),
    .out_min_value   (out_min_value),
    .out_is_empty    (out_is_empty)
  );

endmodule
